// ===== design/iff_pref_chunk_locator_unit_defines.svh =====
// Assertion macros for the PREF chunk locator checker.
// No dependencies; included by the checker file.
`ifndef IFF_PREF_CHUNK_LOCATOR_UNIT_DEFINES_SVH
`define IFF_PREF_CHUNK_LOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define IFPCL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define IFPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ifpcl_pkg.sv =====
// Types and constants shared by the PREF chunk locator.
// No dependencies.
package ifpcl_pkg;

   localparam int MAX_FILE_BYTES_DEFAULT = 4096;

   localparam logic [31:0] TAG_FORM = 32'h464F_524D;
   localparam logic [31:0] TAG_PREF = 32'h5052_4546;
   localparam logic [31:0] TAG_SCRM = 32'h5343_524D;

   localparam logic [31:0] SCRM_MIN_BYTES = 32'd28;
   localparam logic [31:0] FORM_MIN_SIZE  = 32'd4;
   localparam int          FIRST_CHUNK    = 12;
   localparam int          OFFSET_WIDTH   = 12;

   // Offsets of the last byte of each header field
   localparam int HDR_ID_LAST   = 3;
   localparam int HDR_SIZE_LAST = 7;
   localparam int HDR_TYPE_LAST = 11;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_ID,
      PHASE_SIZE_OTHER,
      PHASE_SIZE_SCRM
   } phase_type;

   typedef enum logic [1:0] {
      OUTCOME_UNDECIDED,
      OUTCOME_FOUND,
      OUTCOME_FAILED
   } outcome_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                    prefs_valid;
      logic [OFFSET_WIDTH-1:0] settings_offset;
   } rsp_type;

endpackage

// ===== design/iff_pref_chunk_locator_unit.sv =====
// PREF chunk locator: takes one file byte per request and, on the byte flagged
// last, returns one response with the SCRM payload offset or an invalid flag.
// A byte is taken every cycle, except a last byte while the response slot is busy;
// the response appears the cycle after the last byte is taken and is held in an
// output register. Bytes that are not last are taken even while a response waits;
// a last byte waits until the response slot is free. Files longer than
// MAX_FILE_BYTES are reported invalid.
// Depends on ifpcl_pkg and ifpcl_parser.
module iff_pref_chunk_locator_unit
   import ifpcl_pkg::*;
#(
   parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    step;
   logic    rsp_free;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type result;

   // Accept unless a last byte would land on an occupied response slot
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = rsp_free || !req_data.last_byte;
   assign step      = req_valid && req_ready;

   ifpcl_parser #(
      .MAX_FILE_BYTES (MAX_FILE_BYTES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_data (req_data),
      .result   (result)
   );

   // Load the response on a last byte, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (step && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/ifpcl_parser.sv =====
// Byte-serial FORM/PREF header check and chunk walk, one byte per step.
// Depends on ifpcl_pkg.
module ifpcl_parser
   import ifpcl_pkg::*;
#(
   parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req_data,
   output rsp_type result
);

   localparam int PW = $clog2(MAX_FILE_BYTES + 2);
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_FILE_BYTES);

   logic [PW-1:0]           pos_ff, pos_in;
   logic [31:0]             tag_ff, tag_in;
   logic [32:0]             form_end_ff, form_end_in;
   logic [32:0]             room_ff, room_in;
   logic [33:0]             target_ff, target_in;
   logic [OFFSET_WIDTH-1:0] found_ff, found_in;
   phase_type               phase_ff, phase_in;
   outcome_type             outcome_ff, outcome_in;

   logic                    run;
   logic                    too_long;
   logic                    at_target;
   logic [32:0]             total;
   logic [33:0]             total_hdr;
   logic                    payload_over;
   logic                    header_over;
   logic [PW:0]             length;
   logic [32:0]             length_ext;
   outcome_type             outcome_step;
   logic [32:0]             form_end_step;
   logic [OFFSET_WIDTH-1:0] found_step;

   // Decode the current byte against running state
   assign tag_in       = {tag_ff[23:0], req_data.data_byte};
   assign too_long     = pos_ff >= MAX_POS;
   assign run          = step && !too_long && (outcome_ff == OUTCOME_UNDECIDED);
   assign at_target    = {{(34-PW){1'b0}}, pos_ff} == target_ff;
   assign total        = {1'b0, tag_in} + {32'd0, tag_in[0]};
   assign total_hdr    = {1'b0, total} + 34'd8;
   assign payload_over = total > room_ff;
   assign header_over  = total_hdr > {1'b0, room_ff};

   // Next phase and outcome
   always_comb begin
      phase_in   = phase_ff;
      outcome_in = outcome_ff;
      if (step && too_long) begin
         outcome_in = OUTCOME_FAILED;
      end else if (run) begin
         case (phase_ff)
            PHASE_HEADER: begin
               if (pos_ff == PW'(HDR_ID_LAST) && tag_in != TAG_FORM) begin
                  outcome_in = OUTCOME_FAILED;
               end else if (pos_ff == PW'(HDR_SIZE_LAST) && tag_in < FORM_MIN_SIZE) begin
                  outcome_in = OUTCOME_FAILED;
               end else if (pos_ff == PW'(HDR_TYPE_LAST)) begin
                  if (tag_in != TAG_PREF || form_end_ff < 33'(FIRST_CHUNK + 8)) begin
                     outcome_in = OUTCOME_FAILED;
                  end else begin
                     phase_in = PHASE_ID;
                  end
               end
            end
            PHASE_ID: begin
               if (at_target) begin
                  phase_in = (tag_in == TAG_SCRM) ? PHASE_SIZE_SCRM : PHASE_SIZE_OTHER;
               end
            end
            PHASE_SIZE_SCRM: begin
               if (at_target) begin
                  if (payload_over || tag_in < SCRM_MIN_BYTES) begin
                     outcome_in = OUTCOME_FAILED;
                  end else begin
                     outcome_in = OUTCOME_FOUND;
                  end
               end
            end
            PHASE_SIZE_OTHER: begin
               if (at_target) begin
                  if (payload_over || header_over) begin
                     outcome_in = OUTCOME_FAILED;
                  end else begin
                     phase_in = PHASE_ID;
                  end
               end
            end
            default: begin
               outcome_in = OUTCOME_FAILED;
            end
         endcase
      end
      // keep this byte's outcome for the verdict before clearing
      outcome_step = outcome_in;
      if (step && req_data.last_byte) begin
         phase_in   = PHASE_HEADER;
         outcome_in = OUTCOME_UNDECIDED;
      end
   end

   // Datapath: position, tag window, form end, remaining room, match target
   always_comb begin
      pos_in      = pos_ff;
      form_end_in = form_end_ff;
      room_in     = room_ff;
      target_in   = target_ff;
      found_in    = found_ff;
      if (step && pos_ff <= MAX_POS) begin
         pos_in = pos_ff + PW'(1);
      end
      if (run) begin
         case (phase_ff)
            PHASE_HEADER: begin
               if (pos_ff == PW'(HDR_SIZE_LAST)) begin
                  form_end_in = {1'b0, tag_in} + 33'd8;
               end else if (pos_ff == PW'(HDR_TYPE_LAST)) begin
                  // room counts form bytes past the first chunk header
                  room_in   = form_end_ff - 33'(FIRST_CHUNK + 8);
                  target_in = 34'(FIRST_CHUNK + HDR_ID_LAST);
               end
            end
            PHASE_ID: begin
               if (at_target) begin
                  target_in = target_ff + 34'd4;
               end
            end
            PHASE_SIZE_SCRM: begin
               if (at_target) begin
                  found_in = target_ff[OFFSET_WIDTH-1:0] + OFFSET_WIDTH'(1);
               end
            end
            PHASE_SIZE_OTHER: begin
               if (at_target) begin
                  room_in   = room_ff - total_hdr[32:0];
                  target_in = target_ff + {1'b0, total} + 34'd4;
               end
            end
            default: begin
               target_in = target_ff;
            end
         endcase
      end
      // keep this byte's form end and offset for the verdict before clearing
      form_end_step = form_end_in;
      found_step    = found_in;
      if (step && req_data.last_byte) begin
         pos_in      = '0;
         form_end_in = '0;
         room_in     = '0;
         target_in   = 34'(FIRST_CHUNK);
         found_in    = '0;
      end
   end

   // Verdict for the last byte of a file
   assign length     = {1'b0, pos_ff} + {{PW{1'b0}}, 1'b1};
   assign length_ext = {{(33-PW-1){1'b0}}, length};

   always_comb begin
      result.prefs_valid = (outcome_step == OUTCOME_FOUND) && !too_long
                           && length_ext >= 33'(FIRST_CHUNK)
                           && form_end_step <= length_ext;
      result.settings_offset = result.prefs_valid ? found_step : '0;
   end

   // Hold state between bytes; clear between files
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         tag_ff      <= '0;
         form_end_ff <= '0;
         room_ff     <= '0;
         target_ff   <= 34'(FIRST_CHUNK);
         found_ff    <= '0;
         phase_ff    <= PHASE_HEADER;
         outcome_ff  <= OUTCOME_UNDECIDED;
      end else begin
         pos_ff      <= pos_in;
         form_end_ff <= form_end_in;
         room_ff     <= room_in;
         target_ff   <= target_in;
         found_ff    <= found_in;
         phase_ff    <= phase_in;
         outcome_ff  <= outcome_in;
         if (step) begin
            tag_ff <= req_data.last_byte ? 32'd0 : tag_in;
         end
      end
   end

endmodule

// ===== design/ifpcl_checker.sv =====
// Port-level checks for the PREF chunk locator, bound to the top level.
// Depends on ifpcl_pkg and iff_pref_chunk_locator_unit_defines.svh.
`include "iff_pref_chunk_locator_unit_defines.svh"

module ifpcl_checker
   import ifpcl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `IFPCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped before taken")
   `IFPCL_ASSERT_NEXT(a_last_gives_rsp, req_valid && req_ready && req_data.last_byte, rsp_valid, "no response after last byte")
   `IFPCL_ASSERT_NEXT(a_no_spurious_rsp, req_valid && req_ready && !req_data.last_byte && !rsp_valid, !rsp_valid, "response without last byte")
   `IFPCL_ASSERT_NOW(a_invalid_zero, rsp_valid && !rsp_data.prefs_valid, rsp_data.settings_offset == '0, "invalid response with nonzero offset")

endmodule

bind iff_pref_chunk_locator_unit ifpcl_checker u_ifpcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb.sv =====
// Testbench for iff_pref_chunk_locator_unit: feeds PREF files byte by byte as
// requests and checks each response against a built-in parser model, or against
// a pinned expected response. Depends on ifpcl_pkg and the locator RTL.
`timescale 1ns / 1ps

module tb;
   import ifpcl_pkg::*;

   localparam int FILE_LIMIT       = MAX_FILE_BYTES_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 16;
   localparam int RANDOM_BYTES     = 850;
   localparam int RANDOM_FILES     = 40;
   localparam int MAX_REPORTS      = 10;

   localparam rsp_type RSP_INVALID    = '{prefs_valid: 1'b0, settings_offset: '0};
   localparam rsp_type RSP_FIRST_SCRM = '{prefs_valid: 1'b1,
                                          settings_offset: 12'(FIRST_CHUNK + 8)};

   // One file to send: header words, chunk layout and the damage done to it
   typedef struct {
      logic [31:0] head_tag;
      logic [31:0] type_tag;
      bit          raw_size;
      logic [31:0] size_raw;
      int          size_adj;
      int          skip_count;
      int          skip_len;
      logic [31:0] scrm_tag;
      int          scrm_len;   // negative: no SCRM chunk
      int          extra;
      int          pad_to;
      int          cut;
      int          corrupt;
      bit          fixed;
      rsp_type     fixed_rsp;
   } file_spec_t;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type    expected_rsp_q[$];
   logic [7:0] file_image[$];
   int         mismatch_count    = 0;
   int         rsp_count         = 0;
   int         bytes_sent        = 0;
   int         idle_cycles       = 0;
   bit         quiet             = 1'b0;
   bit         long_hold_pending = 1'b0;

   // Parser model state
   logic [12:0] seen_count;
   logic [31:0] tag_window;
   logic [32:0] form_limit;
   logic [31:0] chunk_len;
   logic [33:0] chunk_start;
   phase_type   phase;
   logic [11:0] scrm_offset;
   outcome_type verdict;

   iff_pref_chunk_locator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void locator_clear();
      seen_count  = '0;
      tag_window  = '0;
      form_limit  = '0;
      chunk_len   = '0;
      chunk_start = 34'(FIRST_CHUNK);
      phase       = PHASE_HEADER;
      scrm_offset = '0;
      verdict     = OUTCOME_UNDECIDED;
   endfunction

   // Open the chunk at start, or fail when no header fits in the form
   function automatic void locator_open_chunk(longint unsigned start);
      chunk_start = start[33:0];
      if (start + 8 > 64'(form_limit)) begin
         verdict = OUTCOME_FAILED;
      end else begin
         phase = PHASE_ID;
      end
   endfunction

   function automatic void locator_advance(longint unsigned pos);
      longint unsigned start, payload, room, clen;
      start = 64'(chunk_start);
      case (phase)
         PHASE_HEADER: begin
            if (pos == HDR_ID_LAST && tag_window != TAG_FORM) begin
               verdict = OUTCOME_FAILED;
            end else if (pos == HDR_SIZE_LAST) begin
               if (tag_window < FORM_MIN_SIZE) verdict = OUTCOME_FAILED;
               else form_limit = 33'(tag_window) + 33'd8;
            end else if (pos == HDR_TYPE_LAST) begin
               if (tag_window != TAG_PREF) verdict = OUTCOME_FAILED;
               else locator_open_chunk(FIRST_CHUNK);
            end
         end
         PHASE_ID: begin
            if (pos == start + 3)
               phase = (tag_window == TAG_SCRM) ? PHASE_SIZE_SCRM : PHASE_SIZE_OTHER;
         end
         default: begin
            if (pos == start + 7) begin
               chunk_len = tag_window;
               clen      = 64'(chunk_len);
               payload   = start + 8;
               room      = 64'(form_limit) - payload;
               // Reject a payload or pad byte that runs past the form
               if (clen > room || (clen & 1) > room - clen) begin
                  verdict = OUTCOME_FAILED;
               end else if (phase == PHASE_SIZE_SCRM) begin
                  if (chunk_len < SCRM_MIN_BYTES) begin
                     verdict = OUTCOME_FAILED;
                  end else begin
                     scrm_offset = payload[OFFSET_WIDTH-1:0];
                     verdict     = OUTCOME_FOUND;
                  end
               end else begin
                  locator_open_chunk(payload + clen + (clen & 1));
               end
            end
         end
      endcase
   endfunction

   // Take one byte; return 1 with the predicted response on the last byte
   function automatic bit locator_take_byte(input req_type r, output rsp_type result);
      longint unsigned pos, length;
      bit ok;
      pos        = 64'(seen_count);
      tag_window = {tag_window[23:0], r.data_byte};
      if (pos >= FILE_LIMIT) verdict = OUTCOME_FAILED;
      else if (verdict == OUTCOME_UNDECIDED) locator_advance(pos);
      if (seen_count <= FILE_LIMIT) seen_count = seen_count + 1'b1;
      result = '0;
      if (!r.last_byte) return 1'b0;
      length = pos + 1;
      ok = verdict == OUTCOME_FOUND && length >= FIRST_CHUNK && length <= FILE_LIMIT &&
           64'(form_limit) <= length;
      result.prefs_valid     = ok;
      result.settings_offset = ok ? scrm_offset : '0;
      locator_clear();
      return 1'b1;
   endfunction

   function automatic void put_word(logic [31:0] w);
      for (int k = 3; k >= 0; k--) file_image.push_back(w[8*k +: 8]);
   endfunction

   // Lay out the file bytes described by s into file_image
   function automatic void build_file(file_spec_t s);
      logic [31:0] size_word, id_word;
      int at;
      file_image.delete();
      put_word(s.head_tag);
      put_word('0);
      put_word(s.type_tag);
      repeat (s.skip_count) begin
         id_word = $urandom;
         if (id_word == TAG_SCRM) id_word[0] = ~id_word[0];
         put_word(id_word);
         put_word(s.skip_len);
         repeat (s.skip_len + s.skip_len % 2) file_image.push_back(8'($urandom));
      end
      if (s.scrm_len >= 0) begin
         put_word(s.scrm_tag);
         put_word(s.scrm_len);
         repeat (s.scrm_len) file_image.push_back(8'($urandom));
      end
      size_word = s.raw_size ? s.size_raw : 32'(file_image.size() - 8 + s.size_adj);
      for (int k = 0; k < 4; k++) file_image[4+k] = size_word[31-8*k -: 8];
      repeat (s.extra) file_image.push_back(8'($urandom));
      while (file_image.size() < s.pad_to) file_image.push_back(8'($urandom));
      repeat (s.corrupt) begin
         at = $urandom_range(0, file_image.size() - 1);
         file_image[at] ^= 8'($urandom_range(1, 255));
      end
      if (s.cut > 0) begin
         while (file_image.size() > s.cut) void'(file_image.pop_back());
      end
   endfunction

   // Well-formed PREF file: header and a single minimal SCRM chunk
   function automatic file_spec_t plain_form();
      file_spec_t s;
      s.head_tag   = TAG_FORM;
      s.type_tag   = TAG_PREF;
      s.raw_size   = 1'b0;
      s.size_raw   = '0;
      s.size_adj   = 0;
      s.skip_count = 0;
      s.skip_len   = 0;
      s.scrm_tag   = TAG_SCRM;
      s.scrm_len   = 28;
      s.extra      = 0;
      s.pad_to     = 0;
      s.cut        = 0;
      s.corrupt    = 0;
      s.fixed      = 1'b0;
      s.fixed_rsp  = '0;
      return s;
   endfunction

   function automatic file_spec_t pinned(file_spec_t s, rsp_type want);
      s.fixed     = 1'b1;
      s.fixed_rsp = want;
      return s;
   endfunction

   // Mostly well-formed files with random content, some damaged, some noise
   function automatic file_spec_t random_spec();
      file_spec_t s;
      s = plain_form();
      s.skip_count = $urandom_range(0, 3);
      s.skip_len   = $urandom_range(0, 9);
      s.scrm_len   = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 27)
                                                : $urandom_range(28, 40);
      if ($urandom_range(0, 9) == 0) s.scrm_len = -1;
      if ($urandom_range(0, 3) == 0) s.extra = $urandom_range(1, 12);
      case ($urandom_range(0, 13))
         0: s.head_tag = TAG_FORM ^ (32'd1 << $urandom_range(0, 31));
         1: s.type_tag = TAG_PREF ^ (32'd1 << $urandom_range(0, 31));
         2: begin
            s.raw_size = 1'b1;
            s.size_raw = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom;
         end
         3: s.size_adj = $urandom_range(0, 6) - 3;
         4: s.cut = $urandom_range(1, 60);
         5: s.corrupt = $urandom_range(1, 3);
         6: s.scrm_tag = TAG_SCRM ^ (32'd1 << $urandom_range(0, 31));
         7: begin
            s.head_tag = $urandom;
            s.type_tag = $urandom;
            s.corrupt  = 8;
            s.cut      = $urandom_range(1, 30);
         end
         8: if ($urandom_range(0, 3) == 0) s.pad_to = FILE_LIMIT + $urandom_range(0, 1);
         default: ;
      endcase
      return s;
   endfunction

   // Send one file as a run of byte requests, recording what each causes
   task automatic send_file(file_spec_t s);
      rsp_type predicted;
      bit idle_on;
      build_file(s);
      idle_on = $urandom_range(0, 2) != 0;
      foreach (file_image[i]) begin
         if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{data_byte: file_image[i], last_byte: i == file_image.size() - 1};
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         if (locator_take_byte(req_data, predicted))
            expected_rsp_q.push_back(s.fixed ? s.fixed_rsp : predicted);
         bytes_sent++;
      end
   endtask

   // Drive the response side: short stalls, and one long hold on request
   initial begin : rsp_side
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare each accepted response with the oldest expected one
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("response %0d unexpected: valid=%0d offset=%0d", rsp_count,
                        rsp_data.prefs_valid, rsp_data.settings_offset);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.prefs_valid !== want.prefs_valid ||
                rsp_data.settings_offset !== want.settings_offset) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("response %0d: expected valid=%0d offset=%0d, got valid=%0d offset=%0d",
                           rsp_count, want.prefs_valid, want.settings_offset,
                           rsp_data.prefs_valid, rsp_data.settings_offset);
            end
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      file_spec_t s;
      file_spec_t directed_rows[$];
      int random_files;
      int random_start;
      locator_clear();

      // Short files, including one byte at each extreme value
      s = plain_form(); s.head_tag = '1; s.cut = 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.head_tag = '0; s.cut = 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.cut = FIRST_CHUNK - 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Header only: no room for a chunk header
      s = plain_form(); s.scrm_len = -1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Bad tags and form sizes
      s = plain_form(); s.head_tag = TAG_FORM ^ 32'd1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.type_tag = TAG_PREF ^ 32'h8000_0000;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.raw_size = 1'b1; s.size_raw = FORM_MIN_SIZE - 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.raw_size = 1'b1; s.size_raw = FORM_MIN_SIZE;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.raw_size = 1'b1; s.size_raw = '1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // SCRM at the first chunk, minimal and one short
      s = plain_form();
      directed_rows.push_back(pinned(s, RSP_FIRST_SCRM));
      s = plain_form(); s.scrm_len = 27;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Odd chunk with pad ahead of SCRM
      s = plain_form(); s.skip_count = 1; s.skip_len = 5;
      directed_rows.push_back(s);
      // SCRM payload overrun, then pad overrun
      s = plain_form(); s.size_adj = -1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      s = plain_form(); s.skip_count = 1; s.skip_len = 5; s.scrm_len = -1; s.size_adj = -1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Too few form bytes left for the next chunk header
      s = plain_form(); s.skip_count = 1; s.skip_len = 4; s.scrm_len = -1;
      s.size_adj = 4; s.extra = 4;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Trailing bytes after SCRM, outside and inside the form
      s = plain_form(); s.extra = 50;
      directed_rows.push_back(pinned(s, RSP_FIRST_SCRM));
      s = plain_form(); s.extra = 50; s.size_adj = 50;
      directed_rows.push_back(pinned(s, RSP_FIRST_SCRM));
      // Form one byte beyond the file
      s = plain_form(); s.size_adj = 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Largest file, then one byte too long
      s = plain_form(); s.pad_to = FILE_LIMIT;
      directed_rows.push_back(pinned(s, RSP_FIRST_SCRM));
      s = plain_form(); s.pad_to = FILE_LIMIT + 1;
      directed_rows.push_back(pinned(s, RSP_INVALID));
      // Walks with no SCRM, empty chunks and a longer SCRM
      s = plain_form(); s.skip_count = 3; s.skip_len = 9; s.scrm_tag = TAG_SCRM ^ 32'd1;
      directed_rows.push_back(s);
      s = plain_form(); s.skip_count = 2; s.skip_len = 0;
      directed_rows.push_back(s);
      s = plain_form(); s.skip_count = 1; s.skip_len = 7; s.scrm_len = 40;
      directed_rows.push_back(s);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_file(directed_rows[i]);

      // Random files; hold the receiver at the start, drain once midway
      random_files = 0;
      random_start = bytes_sent;
      long_hold_pending = 1'b1;
      while (bytes_sent - random_start < RANDOM_BYTES || random_files < RANDOM_FILES) begin
         if (random_files == RANDOM_FILES / 2) begin
            req_valid <= 1'b0;
            while (expected_rsp_q.size() != 0) @(posedge clock);
         end
         if (bytes_sent - random_start >= RANDOM_BYTES * 3 / 4 &&
             random_files >= RANDOM_FILES * 3 / 4)
            quiet = 1'b1;
         send_file(random_spec());
         random_files++;
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
